// File: sv/gfau_pkg.sv
// Shared types and constants for the GF(2^8) arithmetic unit.
package gfau_pkg;

    localparam int ELEM_W = 8;
    localparam int KIND_W = 3;
    localparam int STEP_W = 3;

    localparam logic [ELEM_W-1:0] POLY_LOW = 8'h1D;
    localparam logic [ELEM_W-1:0] INV_EXP  = 8'hFE;
    localparam logic [ELEM_W-1:0] ONE      = 8'h01;
    localparam logic [ELEM_W-1:0] ZERO     = 8'h00;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INV = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MULT,
        ST_FINAL
    } state_t;

endpackage

// File: sv/gfau_mul.sv
// Shift-and-XOR field multiplier over x^8+x^4+x^3+x^2+1.
module gfau_mul (
    input  logic [gfau_pkg::ELEM_W-1:0] x,
    input  logic [gfau_pkg::ELEM_W-1:0] y,
    output logic [gfau_pkg::ELEM_W-1:0] p
);

    always_comb
    begin
        logic [gfau_pkg::ELEM_W-1:0] sh;
        logic [gfau_pkg::ELEM_W-1:0] acc;
        sh  = x;
        acc = gfau_pkg::ZERO;
        for (int i = 0; i < gfau_pkg::ELEM_W; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ sh;
            end
            if (sh[gfau_pkg::ELEM_W-1])
            begin
                sh = {sh[gfau_pkg::ELEM_W-2:0], 1'b0} ^ gfau_pkg::POLY_LOW;
            end
            else
            begin
                sh = {sh[gfau_pkg::ELEM_W-2:0], 1'b0};
            end
        end
        p = acc;
    end

endmodule

// File: sv/gf256_arithmetic_unit.sv
// Top level of the GF(2^8) arithmetic unit: sequencer around one shared multiplier.
//
// A word is taken when start is high and busy is low; its result appears on
// result with done high for exactly one cycle and cannot be held off, so the
// receiver must take it then. All products come from one field multiplier, one
// product per cycle. Add, sub, reserved kinds and zero a (pow, inv) or zero a
// or b (div) finish at the accepting edge, so done rises in the next cycle.
// Mul goes through ST_FINAL, which registers its product. Pow takes 8 squarings
// plus one multiply per set exponent bit. Inverse is a^254; div is b^254 times
// a. Busy is high from acceptance until the edge that loads the result, and a
// new word may be started in the same cycle that done is shown.
module gf256_arithmetic_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gfau_pkg::KIND_W-1:0] kind,
    input  logic [gfau_pkg::ELEM_W-1:0] operand_a,
    input  logic [gfau_pkg::ELEM_W-1:0] operand_b,
    output logic                        done,
    output logic [gfau_pkg::ELEM_W-1:0] result
);

    gfau_pkg::state_t state_reg, state_next;

    logic [gfau_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [gfau_pkg::ELEM_W-1:0] a_reg, a_next;
    logic [gfau_pkg::ELEM_W-1:0] base_reg, base_next;
    logic [gfau_pkg::ELEM_W-1:0] exp_reg, exp_next;
    logic [gfau_pkg::ELEM_W-1:0] acc_reg, acc_next;
    logic [gfau_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [gfau_pkg::ELEM_W-1:0] result_reg, result_next;
    logic                        done_reg, done_next;

    logic [gfau_pkg::ELEM_W-1:0] mul_y;
    logic [gfau_pkg::ELEM_W-1:0] prod;
    logic                        accept;
    logic                        a_zero;
    logic                        b_zero;
    logic                        last_step;
    logic                        pow_end;

    assign accept    = start && (state_reg == gfau_pkg::ST_IDLE);
    assign a_zero    = (operand_a == gfau_pkg::ZERO);
    assign b_zero    = (operand_b == gfau_pkg::ZERO);
    assign last_step = (cnt_reg == '0);
    assign pow_end   = last_step && (((state_reg == gfau_pkg::ST_SQUARE) && !exp_reg[7])
                                     || (state_reg == gfau_pkg::ST_MULT));

    always_comb
    begin
        case (state_reg)
            gfau_pkg::ST_MULT:  mul_y = base_reg;
            gfau_pkg::ST_FINAL: mul_y = a_reg;
            default:            mul_y = acc_reg;
        endcase
    end

    gfau_mul u_mul (
        .x (acc_reg),
        .y (mul_y),
        .p (prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gfau_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        gfau_pkg::KIND_MUL:
                            state_next = gfau_pkg::ST_FINAL;
                        gfau_pkg::KIND_DIV:
                            if (!a_zero && !b_zero)
                            begin
                                state_next = gfau_pkg::ST_SQUARE;
                            end
                        gfau_pkg::KIND_POW, gfau_pkg::KIND_INV:
                            if (!a_zero)
                            begin
                                state_next = gfau_pkg::ST_SQUARE;
                            end
                        default:
                            state_next = gfau_pkg::ST_IDLE;
                    endcase
                end
            end
            gfau_pkg::ST_SQUARE, gfau_pkg::ST_MULT:
            begin
                if (pow_end)
                begin
                    state_next = (kind_reg == gfau_pkg::KIND_DIV) ? gfau_pkg::ST_FINAL
                                                                  : gfau_pkg::ST_IDLE;
                end
                else if ((state_reg == gfau_pkg::ST_SQUARE) && exp_reg[7])
                begin
                    state_next = gfau_pkg::ST_MULT;
                end
                else
                begin
                    state_next = gfau_pkg::ST_SQUARE;
                end
            end
            gfau_pkg::ST_FINAL:
                state_next = gfau_pkg::ST_IDLE;
            default:
                state_next = gfau_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        kind_next   = kind_reg;
        a_next      = a_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            gfau_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    a_next    = operand_a;
                    acc_next  = gfau_pkg::ONE;
                    cnt_next  = '1;
                    case (kind)
                        gfau_pkg::KIND_ADD, gfau_pkg::KIND_SUB:
                        begin
                            result_next = operand_a ^ operand_b;
                            done_next   = 1'b1;
                        end
                        gfau_pkg::KIND_MUL:
                            acc_next = operand_b;
                        gfau_pkg::KIND_DIV:
                        begin
                            base_next = operand_b;
                            exp_next  = gfau_pkg::INV_EXP;
                            if (a_zero || b_zero)
                            begin
                                result_next = gfau_pkg::ZERO;
                                done_next   = 1'b1;
                            end
                        end
                        gfau_pkg::KIND_POW:
                        begin
                            base_next = operand_a;
                            exp_next  = operand_b;
                            if (a_zero)
                            begin
                                result_next = gfau_pkg::ZERO;
                                done_next   = 1'b1;
                            end
                        end
                        gfau_pkg::KIND_INV:
                        begin
                            base_next = operand_a;
                            exp_next  = gfau_pkg::INV_EXP;
                            if (a_zero)
                            begin
                                result_next = gfau_pkg::ZERO;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            result_next = gfau_pkg::ZERO;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            gfau_pkg::ST_SQUARE, gfau_pkg::ST_MULT:
            begin
                acc_next = prod;
                if ((state_reg == gfau_pkg::ST_MULT) || !exp_reg[7])
                begin
                    exp_next = {exp_reg[gfau_pkg::ELEM_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                if (pow_end && (kind_reg != gfau_pkg::KIND_DIV))
                begin
                    result_next = prod;
                    done_next   = 1'b1;
                end
            end
            gfau_pkg::ST_FINAL:
            begin
                result_next = prod;
                done_next   = 1'b1;
            end
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gfau_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        a_reg      <= a_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != gfau_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequence ended without a result");

    a_xor_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((kind == gfau_pkg::KIND_ADD) || (kind == gfau_pkg::KIND_SUB)))
        |=> (done && (result == ($past(operand_a) ^ $past(operand_b)))))
        else $error("add/sub result wrong or late");

    a_zero_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && a_zero && ((kind == gfau_pkg::KIND_DIV) || (kind == gfau_pkg::KIND_POW)
                              || (kind == gfau_pkg::KIND_INV)))
        |=> (done && (result == gfau_pkg::ZERO)))
        else $error("zero operand not short-circuited to zero");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == gfau_pkg::KIND_MUL)) |=> (busy && !done))
        else $error("mul did not take its multiply step");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the GF(2^8) arithmetic unit with directed and random words.
`timescale 1ns / 1ps

module testbench;

    localparam logic [gfau_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [gfau_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;
    localparam int RANDOM_WORDS = 1800;
    localparam int PHASES = 4;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [gfau_pkg::KIND_W-1:0] kind;
        logic [gfau_pkg::ELEM_W-1:0] a;
        logic [gfau_pkg::ELEM_W-1:0] b;
        int unsigned                 gap_pct;
        bit                          drain_first;
    } word_t;

    typedef struct {
        logic [gfau_pkg::KIND_W-1:0] kind;
        logic [gfau_pkg::ELEM_W-1:0] a;
        logic [gfau_pkg::ELEM_W-1:0] b;
        logic [gfau_pkg::ELEM_W-1:0] value;
    } field_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [gfau_pkg::KIND_W-1:0] kind;
    logic [gfau_pkg::ELEM_W-1:0] operand_a;
    logic [gfau_pkg::ELEM_W-1:0] operand_b;
    logic                        done;
    logic [gfau_pkg::ELEM_W-1:0] result;

    word_t         word_queue[$];
    field_result_t expected_bytes[$];
    bit            taken;
    int            error_count;

    gf256_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [gfau_pkg::ELEM_W-1:0] gf_times(
        logic [gfau_pkg::ELEM_W-1:0] x,
        logic [gfau_pkg::ELEM_W-1:0] y);
        logic [gfau_pkg::ELEM_W-1:0] acc;
        logic [gfau_pkg::ELEM_W-1:0] sh;
        acc = gfau_pkg::ZERO;
        sh = x;
        for (int i = 0; i < gfau_pkg::ELEM_W; i++)
        begin
            if (y[i])
                acc = acc ^ sh;
            if (sh[gfau_pkg::ELEM_W-1])
                sh = (sh << 1) ^ gfau_pkg::POLY_LOW;
            else
                sh = sh << 1;
        end
        return acc;
    endfunction

    function automatic logic [gfau_pkg::ELEM_W-1:0] gf_raise(
        logic [gfau_pkg::ELEM_W-1:0] base,
        logic [gfau_pkg::ELEM_W-1:0] e);
        logic [gfau_pkg::ELEM_W-1:0] r;
        r = gfau_pkg::ONE;
        if (base == gfau_pkg::ZERO)
            return gfau_pkg::ZERO;
        for (int i = gfau_pkg::ELEM_W - 1; i >= 0; i--)
        begin
            r = gf_times(r, r);
            if (e[i])
                r = gf_times(r, base);
        end
        return r;
    endfunction

    function automatic logic [gfau_pkg::ELEM_W-1:0] gf_result(
        logic [gfau_pkg::KIND_W-1:0] k,
        logic [gfau_pkg::ELEM_W-1:0] a,
        logic [gfau_pkg::ELEM_W-1:0] b);
        case (k)
            gfau_pkg::KIND_ADD, gfau_pkg::KIND_SUB: return a ^ b;
            gfau_pkg::KIND_MUL: return gf_times(a, b);
            gfau_pkg::KIND_DIV:
                return (a == gfau_pkg::ZERO || b == gfau_pkg::ZERO)
                       ? gfau_pkg::ZERO : gf_times(a, gf_raise(b, gfau_pkg::INV_EXP));
            gfau_pkg::KIND_POW: return gf_raise(a, b);
            gfau_pkg::KIND_INV: return gf_raise(a, gfau_pkg::INV_EXP);
            default: return gfau_pkg::ZERO;
        endcase
    endfunction

    function automatic logic [gfau_pkg::ELEM_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return gfau_pkg::ZERO;
        if (r < 15)
            return gfau_pkg::ONE;
        if (r < 20)
            return 8'hFF;
        return gfau_pkg::ELEM_W'($urandom_range(255));
    endfunction

    function automatic logic [gfau_pkg::KIND_W-1:0] pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return gfau_pkg::KIND_ADD;
        if (r < 16)
            return gfau_pkg::KIND_SUB;
        if (r < 44)
            return gfau_pkg::KIND_MUL;
        if (r < 62)
            return gfau_pkg::KIND_DIV;
        if (r < 80)
            return gfau_pkg::KIND_POW;
        if (r < 95)
            return gfau_pkg::KIND_INV;
        if (r < 97)
            return KIND_RSVD6;
        return KIND_RSVD7;
    endfunction

    task automatic add_word(logic [gfau_pkg::KIND_W-1:0] k,
                            logic [gfau_pkg::ELEM_W-1:0] a,
                            logic [gfau_pkg::ELEM_W-1:0] b,
                            int unsigned gap_pct, bit drain_first);
        word_t w;
        w.kind = k;
        w.a = a;
        w.b = b;
        w.gap_pct = gap_pct;
        w.drain_first = drain_first;
        word_queue.push_back(w);
    endtask

    always @(negedge clk)
    begin
        word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !taken))
        begin
            taken = 1'b0;
            if (word_queue.size() == 0)
                start <= 1'b0;
            else if (word_queue[0].drain_first && (expected_bytes.size() != 0 || busy))
                start <= 1'b0;
            else if ($urandom_range(99) < word_queue[0].gap_pct)
                start <= 1'b0;
            else
            begin
                w = word_queue.pop_front();
                start <= 1'b1;
                kind <= w.kind;
                operand_a <= w.a;
                operand_b <= w.b;
            end
        end
    end

    always @(posedge clk)
    begin
        field_result_t exp_res;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_bytes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result %02h with nothing pending", result);
                end
                else
                begin
                    exp_res = expected_bytes.pop_front();
                    if (result !== exp_res.value)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch kind %0d a %02h b %02h: expected %02h, got %02h",
                                     exp_res.kind, exp_res.a, exp_res.b, exp_res.value, result);
                    end
                end
            end
            if (start && !busy)
            begin
                taken = 1'b1;
                exp_res.kind = kind;
                exp_res.a = operand_a;
                exp_res.b = operand_b;
                exp_res.value = gf_result(kind, operand_a, operand_b);
                expected_bytes.push_back(exp_res);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned phase_gap[PHASES];
        logic [gfau_pkg::KIND_W-1:0] k;
        phase_gap = '{0, 50, 26, 0};
        rst_n = 1'b0;
        start = 1'b0;
        kind = gfau_pkg::KIND_ADD;
        operand_a = gfau_pkg::ZERO;
        operand_b = gfau_pkg::ZERO;
        taken = 1'b0;
        error_count = 0;

        add_word(gfau_pkg::KIND_ADD, 8'h00, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_ADD, 8'hFF, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_ADD, 8'hA5, 8'h5A, 0, 1'b0);
        add_word(gfau_pkg::KIND_SUB, 8'hFF, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_MUL, 8'h00, 8'h37, 0, 1'b0);
        add_word(gfau_pkg::KIND_MUL, 8'h91, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_MUL, 8'hFF, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_MUL, 8'h80, 8'h02, 0, 1'b0);
        add_word(gfau_pkg::KIND_DIV, 8'h00, 8'h53, 0, 1'b0);
        add_word(gfau_pkg::KIND_DIV, 8'hC4, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_DIV, 8'hFF, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_DIV, 8'h01, 8'h02, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'h00, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'h00, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'h07, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'h02, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'hFF, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_POW, 8'h03, 8'h08, 0, 1'b0);
        add_word(gfau_pkg::KIND_INV, 8'h00, 8'hFF, 0, 1'b0);
        add_word(gfau_pkg::KIND_INV, 8'h01, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_INV, 8'hFF, 8'h00, 0, 1'b0);
        add_word(gfau_pkg::KIND_INV, 8'h02, 8'h55, 0, 1'b0);
        add_word(KIND_RSVD6, 8'hFF, 8'hFF, 0, 1'b0);
        add_word(KIND_RSVD7, 8'h5A, 8'hA5, 0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < RANDOM_WORDS / PHASES; i++)
            begin
                k = pick_kind();
                if (k == gfau_pkg::KIND_POW)
                    add_word(k, pick_elem(), gfau_pkg::ELEM_W'($urandom_range(255)),
                             phase_gap[p], i == 0);
                else
                    add_word(k, pick_elem(), pick_elem(), phase_gap[p], i == 0);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (word_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: gf256_arithmetic_unit.f
sv/gfau_pkg.sv
sv/gfau_mul.sv
sv/gf256_arithmetic_unit.sv
test/testbench.sv
